@@ sv/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
// No dependencies; every other file of the block imports this package.
package ple_pkg;

    localparam int POS_W        = 6;
    localparam int DATA_W       = 32;
    localparam int ACT_W        = 2;
    localparam int ST_W         = 3;
    localparam int CAPACITY_DEF = 32;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 16;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] match_position;
        logic             last;
        logic [POS_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [POS_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [POS_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

@@ sv/ple_ram.sv @@
// Entry store of the positional list engine: one write and one read port,
// registered read data that holds while no read is issued. Uses ple_pkg.
module ple_ram #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF
) (
    input  logic                      clk,
    input  ple_pkg::ram_req_t         req,
    output logic [ple_pkg::DATA_W-1:0] rd_data
);
    import ple_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ple_outbuf.sv @@
// One-word output register that parts the sequencer from the result stream.
// Uses ple_pkg for the result type.
module ple_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ple_pkg::result_t in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output ple_pkg::result_t out_word
);
    import ple_pkg::*;

    logic    full_reg;
    result_t word_reg;

    assign in_ready  = !full_reg || out_ready;
    assign out_valid = full_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

@@ sv/ple_ctrl.sv @@
// Sequencer of the positional list engine: decodes a command, streams the
// entry store through one shift/compare path, and forms results. Uses ple_pkg.
module ple_ctrl #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ple_pkg::ACT_W-1:0]  in_action,
    input  logic [ple_pkg::POS_W-1:0]  in_position,
    input  logic [ple_pkg::DATA_W-1:0] in_value,
    output ple_pkg::ram_req_t          ram_req,
    input  logic [ple_pkg::DATA_W-1:0] ram_rdata,
    output logic                       res_valid,
    input  logic                       res_ready,
    output ple_pkg::result_t           res
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t            state_reg,   state_next;
    logic [POS_W-1:0]  count_reg,   count_next;
    logic [ACT_W-1:0]  op_reg,      op_next;
    logic [ST_W-1:0]   status_reg,  status_next;
    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [DATA_W-1:0] val_reg,     val_next;
    logic [POS_W-1:0]  src_reg,     src_next;
    logic [POS_W-1:0]  left_reg,    left_next;
    logic              dvld_reg,    dvld_next;
    logic [POS_W-1:0]  dpos_reg,    dpos_next;
    logic              hit_vld_reg, hit_vld_next;
    logic [POS_W-1:0]  hit_pos_reg, hit_pos_next;

    logic [POS_W:0]   cnt_ext;
    logic [POS_W:0]   pos_ext;
    logic             match;
    logic             stall;
    logic [POS_W-1:0] count_after;

    assign in_ready = (state_reg == S_IDLE);
    assign cnt_ext  = {1'b0, count_reg};
    assign pos_ext  = {1'b0, in_position};
    assign match    = dvld_reg && (op_reg == ACT_SEARCH) && (ram_rdata == val_reg);
    assign stall    = match && hit_vld_reg && !res_ready;

    always_comb
    begin
        case (status_reg)
            ST_INSERTED: count_after = count_reg + POS_W'(1);
            ST_DELETED:  count_after = count_reg - POS_W'(1);
            default:     count_after = count_reg;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        status_next  = status_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        src_next     = src_reg;
        left_next    = left_reg;
        dvld_next    = dvld_reg;
        dpos_next    = dpos_reg;
        hit_vld_next = hit_vld_reg;
        hit_pos_next = hit_pos_reg;
        ram_req      = '0;
        res_valid    = 1'b0;
        res          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_action;
                    pos_next     = in_position;
                    val_next     = in_value;
                    left_next    = '0;
                    src_next     = '0;
                    dvld_next    = 1'b0;
                    hit_vld_next = 1'b0;
                    state_next   = S_RUN;
                    case (in_action)
                        ACT_INSERT:
                        begin
                            if ((in_position == '0) || (pos_ext > cnt_ext + (POS_W+1)'(1)))
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (count_reg == POS_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                // Move entries from the tail down to the slot.
                                status_next = ST_INSERTED;
                                src_next    = count_reg - POS_W'(1);
                                left_next   = POS_W'(cnt_ext + (POS_W+1)'(1) - pos_ext);
                            end
                        end
                        ACT_DELETE:
                        begin
                            if ((in_position == '0) || (pos_ext > cnt_ext))
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                status_next = ST_DELETED;
                                src_next    = in_position;
                                left_next   = count_reg - in_position;
                            end
                        end
                        ACT_SEARCH:
                        begin
                            status_next = ST_NOT_FOUND;
                            left_next   = count_reg;
                        end
                        default:
                        begin
                            status_next = ST_BAD_POS;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // A new hit releases the previous one, which is not the last.
                if (match && hit_vld_reg)
                begin
                    res_valid          = 1'b1;
                    res.status         = ST_FOUND;
                    res.match_position = hit_pos_reg;
                    res.last           = 1'b0;
                    res.entry_count    = count_reg;
                end
                if (!stall)
                begin
                    if (match)
                    begin
                        hit_vld_next = 1'b1;
                        hit_pos_next = dpos_reg + POS_W'(1);
                    end
                    if (dvld_reg && (op_reg != ACT_SEARCH))
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = (op_reg == ACT_INSERT) ? dpos_reg + POS_W'(1)
                                                                 : dpos_reg - POS_W'(1);
                        ram_req.wr_data = ram_rdata;
                    end
                    if (left_reg != '0)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = src_reg;
                        dvld_next       = 1'b1;
                        dpos_next       = src_reg;
                        src_next        = (op_reg == ACT_INSERT) ? src_reg - POS_W'(1)
                                                                 : src_reg + POS_W'(1);
                        left_next       = left_reg - POS_W'(1);
                    end
                    else
                    begin
                        dvld_next = 1'b0;
                        if (!dvld_reg)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_FIN:
            begin
                res_valid          = 1'b1;
                res.status         = hit_vld_reg ? ST_FOUND : status_reg;
                res.match_position = hit_vld_reg ? hit_pos_reg : '0;
                res.last           = 1'b1;
                res.entry_count    = count_after;
                if (res_ready)
                begin
                    if (status_reg == ST_INSERTED)
                    begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = pos_reg - POS_W'(1);
                        ram_req.wr_data = val_reg;
                    end
                    count_next   = count_after;
                    hit_vld_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            left_reg    <= '0;
            dvld_reg    <= 1'b0;
            hit_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            left_reg    <= left_next;
            dvld_reg    <= dvld_next;
            hit_vld_reg <= hit_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        src_reg     <= src_next;
        dpos_reg    <= dpos_next;
        hit_pos_reg <= hit_pos_next;
    end

endmodule

@@ sv/positional_list_engine.sv @@
// An insert or a delete gives one result word once any entries have moved; a search gives a
// found word for each hit, each earlier one going out when the next hit is found, and a final
// word with the last flag, which reads not found when there was no hit.
// One command at a time: the next is taken only after the final result word of the last one
// has gone into the output register, as entries are moved or scanned through the single read port.
// Reset (rst_n, asynchronous, active low) empties the list; the entry store itself is not cleared.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0] s_axis_tdata,  // position[5:0], value[37:6], zero pad
    input  logic [ple_pkg::S_TUSER_W-1:0] s_axis_tuser,  // action[1:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ple_pkg::M_TDATA_W-1:0] m_axis_tdata,  // status[2:0], match_position[8:3],
                                                         // entry_count[14:9], zero pad
    output logic                          m_axis_tlast
);
    import ple_pkg::*;

    // The sequencer and the entry store talk through one request struct;
    // results pass through a one-word register so that the consumer may stall.
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    result_t           res;
    result_t           out_word;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser[ACT_W-1:0]),
        .in_position (s_axis_tdata[POS_W-1:0]),
        .in_value    (s_axis_tdata[POS_W+DATA_W-1:POS_W]),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ple_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    ple_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_word   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    // Pack the result word, the first field in the lowest bits.
    assign m_axis_tdata = {1'b0, out_word.entry_count, out_word.match_position, out_word.status};
    assign m_axis_tlast = out_word.last;

`ifndef SYNTHESIS
    // A command occupies the sequencer, so the input is not ready right after an acceptance.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in consecutive cycles");

    // Only a search with further hits leaves a word that is not the last.
    a_nonlast_is_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[2:0] == ST_FOUND)
        else $error("non-last result that is not a found result");

    // A found position lies within the list; every other result carries position zero.
    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_FOUND)
            ? (m_axis_tdata[8:3] != '0 && m_axis_tdata[8:3] <= m_axis_tdata[14:9])
            : (m_axis_tdata[8:3] == '0))
        else $error("match position inconsistent with status or entry count");

    // The list never grows beyond its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:9] <= POS_W'(CAPACITY))
        else $error("entry count above capacity");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for positional_list_engine: random and directed list commands,
// with every result word checked against a behavioural copy of the ordered list.
// Depends on ple_pkg and positional_list_engine only.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 45;   // result words seen before the long receiver hold-off
    localparam int HOLD_LEN    = 300;  // length of that hold-off in cycles
    localparam int IDLE_PCT    = 14;

    // The action encoding leaves one code unused; the block answers it as a bad position.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        bit                       wait_drain;  // hold this word back until all results are in
    } list_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    positional_list_engine #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Commands waiting to be offered, and result words the list is expected to produce.
    list_cmd_t pending_cmds[$];
    result_t   expected_results[$];

    // Behavioural copy of the list contents and its length.
    logic signed [DATA_W-1:0] list_vals[LIST_CAP];
    int                       list_len = 0;

    // Length of the list as the stimulus generator expects it to be once all queued
    // commands have been applied; used only to pick sensible positions.
    int gen_len = 0;

    int  cmds_accepted = 0;
    int  results_seen = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  offering_idle;
    logic steady;

    list_cmd_t offered_cmd;

    // Neither side idles while these commands are going through.
    assign steady = (cmds_accepted >= 70) && (cmds_accepted < 100);

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_error(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got !== want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Applies one accepted command to the list copy and queues the result words it causes.
    task automatic predict_list_results(input list_cmd_t cmd);
        result_t res;
        int      pos;
        int      last_hit;

        pos = cmd.position;
        res.status = ST_BAD_POS;
        res.match_position = '0;
        res.last = 1'b1;

        case (cmd.action)
            ACT_INSERT:
            begin
                // The position check takes precedence over the full check.
                if (pos < 1 || pos > list_len + 1)
                    res.status = ST_BAD_POS;
                else if (list_len >= LIST_CAP)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i >= pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos-1] = cmd.value;
                    list_len++;
                    res.status = ST_INSERTED;
                end
            end
            ACT_DELETE:
            begin
                if (pos < 1 || pos > list_len)
                    res.status = ST_BAD_POS;
                else
                begin
                    for (int i = pos - 1; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                    res.status = ST_DELETED;
                end
            end
            ACT_SEARCH:
            begin
                // One found word per matching position, in ascending order, the final one
                // carrying the last flag; a single not-found word if nothing matches.
                last_hit = -1;
                for (int i = 0; i < list_len; i++)
                    if (list_vals[i] == cmd.value)
                        last_hit = i;
                if (last_hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = 0; i <= last_hit; i++)
                    begin
                        if (list_vals[i] == cmd.value)
                        begin
                            res.status = ST_FOUND;
                            res.match_position = POS_W'(i + 1);
                            res.last = (i == last_hit);
                            res.entry_count = POS_W'(list_len);
                            expected_results.push_back(res);
                        end
                    end
                    return;
                end
            end
            default:
                res.status = ST_BAD_POS;
        endcase

        res.entry_count = POS_W'(list_len);
        expected_results.push_back(res);
    endtask

    // Queues a command and keeps the generator's idea of the list length up to date.
    task automatic queue_cmd(input logic [ACT_W-1:0] action, input int pos,
                             input logic signed [DATA_W-1:0] value, input bit wait_drain = 1'b0);
        list_cmd_t cmd;

        cmd.action = action;
        cmd.position = POS_W'(pos);
        cmd.value = value;
        cmd.wait_drain = wait_drain;
        pending_cmds.push_back(cmd);
        if (action == ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < LIST_CAP)
            gen_len++;
        else if (action == ACT_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    // Driver: offers the next pending command whenever the previous word has gone, with
    // random gaps. A command marked to wait is held until every result word has arrived.
    always @(posedge clk)
    begin
        list_cmd_t next_cmd;

        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_list_results(offered_cmd);
                cmds_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                offering_idle = !steady && ($urandom_range(99) < IDLE_PCT);
                if (pending_cmds.size() != 0 && !offering_idle
                    && !(pending_cmds[0].wait_drain && expected_results.size() != 0))
                begin
                    next_cmd = pending_cmds.pop_front();
                    offered_cmd = next_cmd;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, next_cmd.value, next_cmd.position};
                    s_axis_tuser <= next_cmd.action;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off while the sender keeps offering
    // commands, so that the block backs up and stops accepting.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: every accepted result word is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_error($sformatf("unexpected result word, status %0d",
                                       m_axis_tdata[2:0]));
            else
            begin
                want = expected_results.pop_front();
                check_field("status", m_axis_tdata[2:0], want.status);
                check_field("match_position", m_axis_tdata[8:3], want.match_position);
                check_field("last", m_axis_tlast, want.last);
                check_field("entry_count", m_axis_tdata[14:9], want.entry_count);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic signed [DATA_W-1:0] pool[4];
        int                       pick;

        for (int i = 0; i < LIST_CAP; i++)
            list_vals[i] = '0;

        // Directed part: empty-list cases, extreme values, positions at the ends and in the
        // middle, bad positions of both kinds, the unused action and multiple matches.
        queue_cmd(ACT_SEARCH, 0, 32'sd5);              // search in an empty list
        queue_cmd(ACT_DELETE, 1, 32'sd0);              // delete from an empty list
        queue_cmd(ACT_INSERT, 0, 32'sd1);              // position zero
        queue_cmd(ACT_INSERT, 2, 32'sd1);              // beyond count + 1
        queue_cmd(ACT_INSERT, 1, 32'sh7FFF_FFFF);
        queue_cmd(ACT_INSERT, 2, 32'sh8000_0000);      // append
        queue_cmd(ACT_INSERT, 1, -32'sd1);             // in front
        queue_cmd(ACT_INSERT, 2, 32'sh7FFF_FFFF);      // in the middle
        queue_cmd(ACT_SEARCH, 0, 32'sh7FFF_FFFF);      // two matches
        queue_cmd(ACT_SEARCH, 63, 32'sh8000_0000);     // position ignored by a search
        queue_cmd(ACT_SEARCH, 0, 32'sd0);              // no match
        queue_cmd(ACT_DELETE, 0, 32'sd0);
        queue_cmd(ACT_DELETE, 5, 32'sd0);              // beyond count
        queue_cmd(ACT_INSERT, 63, 32'sd0);
        queue_cmd(ACT_UNUSED, 63, -32'sd1);
        queue_cmd(ACT_DELETE, 4, 32'sd0);              // last entry
        queue_cmd(ACT_DELETE, 1, 32'sd0);              // first entry
        queue_cmd(ACT_SEARCH, 0, -32'sd1);
        queue_cmd(ACT_SEARCH, 0, 32'sh7FFF_FFFF);
        queue_cmd(ACT_DELETE, 2, 32'sd0);
        queue_cmd(ACT_DELETE, 1, 32'sd0);              // back to empty
        queue_cmd(ACT_SEARCH, 0, 32'sh7FFF_FFFF);

        // A small pool of values so that searches find several matches.
        for (int i = 0; i < 4; i++)
            pool[i] = $urandom;

        // Fill the list to capacity; the first of these waits until the directed results
        // are all in, so the sender pauses once with the block fully drained.
        while (gen_len < LIST_CAP)
        begin
            pick = $urandom_range(99);
            queue_cmd(ACT_INSERT, $urandom_range(gen_len + 1, 1),
                      pick < 55 ? pool[0] : (pick < 90 ? pool[$urandom_range(3)] : $urandom),
                      gen_len == 0);
        end

        // Full list: a valid position is refused as full, a bad one as a bad position.
        queue_cmd(ACT_INSERT, LIST_CAP + 1, $urandom);
        queue_cmd(ACT_INSERT, $urandom_range(LIST_CAP, 1), $urandom);
        queue_cmd(ACT_INSERT, LIST_CAP + 2, $urandom);
        queue_cmd(ACT_INSERT, 0, $urandom);
        queue_cmd(ACT_SEARCH, $urandom_range(63), pool[0]);
        queue_cmd(ACT_SEARCH, $urandom_range(63), pool[1]);
        queue_cmd(ACT_SEARCH, $urandom_range(63), $urandom);

        // Mixed traffic, mostly well-formed, with some noise.
        repeat (55)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                queue_cmd(ACT_INSERT, $urandom_range(gen_len + 1, 1),
                          $urandom_range(99) < 70 ? pool[$urandom_range(3)] : $urandom);
            else if (pick < 72)
                queue_cmd(ACT_DELETE,
                          gen_len > 0 ? $urandom_range(gen_len, 1) : $urandom_range(63),
                          $urandom);
            else if (pick < 90)
                queue_cmd(ACT_SEARCH, $urandom_range(63),
                          $urandom_range(99) < 80 ? pool[$urandom_range(3)] : $urandom);
            else if (pick < 95)
                queue_cmd(ACT_UNUSED, $urandom_range(63), $urandom);
            else
                queue_cmd($urandom_range(1) ? ACT_INSERT : ACT_DELETE, $urandom_range(63),
                          $urandom);
        end

        // Wait for the last command to go in and every expected word to come out, then
        // allow for a full scan in case the block produces something extra.
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (LIST_CAP + 16) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ positional_list_engine.f @@
sv/ple_pkg.sv
sv/ple_ram.sv
sv/ple_outbuf.sv
sv/ple_ctrl.sv
sv/positional_list_engine.sv
tb/sv/testbench.sv
